>>> design/quadratic_probe_hash_table_macros.svh
// Assertion macros for the port-level checker (qpht_checker) of the hash table block.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef QUADRATIC_PROBE_HASH_TABLE_MACROS_SVH
`define QUADRATIC_PROBE_HASH_TABLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QPHT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hash table check failed");

// The consequent must hold in the cycle after the antecedent.
`define QPHT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hash table check failed");

`endif

>>> design/qpht_pkg.sv
// Shared types, widths and codes of the quadratic probe hash table.
// Used by every module of the block but qpht_ram; depends on nothing else.
package qpht_pkg;

	localparam int TABLE_DEPTH  = 128;
	localparam int SLOT_W       = $clog2(TABLE_DEPTH);
	localparam int SIZE_W       = 8;
	localparam int MOD_W        = SIZE_W;
	localparam int MAX_M        = (TABLE_DEPTH > 255) ? 255 : TABLE_DEPTH;
	localparam int COEFF_W      = 10;
	localparam int KEY_W        = 32;
	localparam int SLOT_OUT_W   = 7;
	localparam int OUT_DATA_W   = 8;
	localparam int CFG_ADDR_W   = 2;
	localparam int CFG_DATA_W   = 10;
	localparam int DIGIT_W      = 4;
	localparam int KEY_DIGITS   = KEY_W / DIGIT_W;
	localparam int COEFF_DIGITS = (COEFF_W + 2 + DIGIT_W - 1) / DIGIT_W;
	localparam int COEFF_SHIFT  = KEY_W - COEFF_DIGITS * DIGIT_W;
	localparam int DCNT_W       = $clog2(KEY_DIGITS + 1);

	typedef logic [MOD_W-1:0]      mod_t;
	typedef logic [SLOT_W-1:0]     slot_idx_t;
	typedef logic [KEY_W-1:0]      key_t;
	typedef logic [DCNT_W-1:0]     dcnt_t;
	typedef logic [OUT_DATA_W-1:0] out_data_t;

	typedef enum logic {
		REQ_INSERT = 1'b0,
		REQ_SEARCH = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		OUT_INSERTED  = 2'd0,
		OUT_FULL      = 2'd1,
		OUT_FOUND     = 2'd2,
		OUT_NOT_FOUND = 2'd3
	} outcome_t;

	typedef enum logic [CFG_ADDR_W-1:0] {
		CFG_TABLE_SIZE   = 2'd0,
		CFG_LINEAR_COEFF = 2'd1,
		CFG_SQUARE_COEFF = 2'd2
	} cfg_index_t;

	// Which value the remainder unit is reducing.
	typedef enum logic [1:0] {
		MOD_KEY  = 2'd0,
		MOD_LIN  = 2'd1,
		MOD_STEP = 2'd2
	} mod_sel_t;

	typedef struct packed {
		logic     accept;
		logic     mod_start;
		mod_sel_t mod_sel;
		logic     probe_adv;
		logic     commit;
	} ctl_cmd_t;

	typedef struct packed {
		logic mod_done;
		logic finish;
		logic out_free;
	} dp_stat_t;

endpackage

>>> design/qpht_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; holds the stored keys of the hash table.
module qpht_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> design/qpht_rem.sv
// Iterative remainder unit: reduces a 32-bit dividend modulo an 8-bit divisor,
// one 4-bit digit per cycle. Depends on qpht_pkg.
module qpht_rem (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  qpht_pkg::key_t    dividend,
	input  qpht_pkg::dcnt_t   digits,
	input  qpht_pkg::mod_t    divisor,
	output logic              done,
	output qpht_pkg::mod_t    rem
);

	qpht_pkg::dcnt_t      cnt_q;
	logic                 done_q;
	qpht_pkg::key_t       div_q;
	qpht_pkg::mod_t       rem_q;
	qpht_pkg::mod_t       rem_nx;
	logic [qpht_pkg::MOD_W:0] trial;

	// Restoring recurrence: the partial remainder stays below the divisor, so
	// one conditional subtraction per dividend bit is enough.
	always_comb begin
		rem_nx = rem_q;
		trial  = '0;
		for (int k = 0; k < qpht_pkg::DIGIT_W; k++) begin
			trial = {rem_nx, div_q[qpht_pkg::KEY_W-1-k]};
			if (trial >= {1'b0, divisor}) begin
				trial = trial - {1'b0, divisor};
			end
			rem_nx = trial[qpht_pkg::MOD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= !start && (cnt_q == qpht_pkg::dcnt_t'(1));
			if (start) begin
				cnt_q <= digits;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - qpht_pkg::dcnt_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= dividend;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			div_q <= div_q << qpht_pkg::DIGIT_W;
			rem_q <= rem_nx;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

>>> design/qpht_dp.sv
// Datapath of the hash table: configuration registers, probe arithmetic, key memory,
// occupancy flags and the result register. Depends on qpht_pkg, qpht_rem, qpht_ram.
module qpht_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  qpht_pkg::ctl_cmd_t                   cmd,
	output qpht_pkg::dp_stat_t                   stat,
	input  qpht_pkg::key_t                       s_tdata,
	input  logic                                 s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output qpht_pkg::out_data_t                  m_tdata,
	output logic [1:0]                           m_tuser,
	input  logic                                 cfg_we,
	input  logic [qpht_pkg::CFG_ADDR_W-1:0]      cfg_addr,
	input  logic [qpht_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

	logic [qpht_pkg::SIZE_W-1:0]  size_q;
	logic [qpht_pkg::COEFF_W-1:0] lin_coeff_q;
	logic [qpht_pkg::COEFF_W-1:0] sq_coeff_q;
	qpht_pkg::mod_t               m_eff;

	qpht_pkg::key_t               key_q;
	qpht_pkg::req_t               req_q;
	qpht_pkg::mod_sel_t           sel_q;
	qpht_pkg::mod_t               pos_q;
	qpht_pkg::mod_t               delta_q;
	qpht_pkg::mod_t               step_q;
	qpht_pkg::mod_t               idx_q;
	logic [qpht_pkg::TABLE_DEPTH-1:0] occ_q;

	logic                         out_valid_q;
	qpht_pkg::outcome_t           outcome_q;
	logic [qpht_pkg::SLOT_OUT_W-1:0] slot_q;

	qpht_pkg::key_t               s_abs;
	logic [qpht_pkg::COEFF_W:0]   lin_sum;
	logic [qpht_pkg::COEFF_W:0]   step_sum;
	qpht_pkg::key_t               dividend;
	qpht_pkg::dcnt_t              digits;
	logic                         rem_done;
	qpht_pkg::mod_t               rem_val;
	qpht_pkg::mod_t               home;

	logic [qpht_pkg::MOD_W:0]     pos_sum;
	logic [qpht_pkg::MOD_W:0]     delta_sum;
	qpht_pkg::mod_t               pos_next;
	qpht_pkg::mod_t               delta_next;

	qpht_pkg::slot_idx_t          ram_addr;
	qpht_pkg::key_t               ram_rdata;
	logic                         ram_we;
	logic                         occ_hit;
	logic                         key_match;
	logic                         last_probe;
	qpht_pkg::outcome_t           res_outcome;
	logic [qpht_pkg::SLOT_OUT_W-1:0] res_slot;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q      <= qpht_pkg::SIZE_W'(128);
			lin_coeff_q <= qpht_pkg::COEFF_W'(1);
			sq_coeff_q  <= qpht_pkg::COEFF_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_addr)
				qpht_pkg::CFG_TABLE_SIZE:   size_q      <= cfg_wdata[qpht_pkg::SIZE_W-1:0];
				qpht_pkg::CFG_LINEAR_COEFF: lin_coeff_q <= cfg_wdata[qpht_pkg::COEFF_W-1:0];
				qpht_pkg::CFG_SQUARE_COEFF: sq_coeff_q  <= cfg_wdata[qpht_pkg::COEFF_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (size_q == '0) begin
			m_eff = qpht_pkg::mod_t'(1);
		end else if (size_q > qpht_pkg::mod_t'(qpht_pkg::MAX_M)) begin
			m_eff = qpht_pkg::mod_t'(qpht_pkg::MAX_M);
		end else begin
			m_eff = size_q;
		end
	end

	// Residues needed before probing: the key magnitude, the first probe
	// step c1 + c2 and the second difference 2 * c2.
	assign s_abs    = s_tdata[qpht_pkg::KEY_W-1] ? qpht_pkg::key_t'(-s_tdata) : s_tdata;
	assign lin_sum  = {1'b0, lin_coeff_q} + {1'b0, sq_coeff_q};
	assign step_sum = {sq_coeff_q, 1'b0};

	always_comb begin
		unique case (cmd.mod_sel)
			qpht_pkg::MOD_LIN: begin
				dividend = qpht_pkg::key_t'(lin_sum) << qpht_pkg::COEFF_SHIFT;
				digits   = qpht_pkg::dcnt_t'(qpht_pkg::COEFF_DIGITS);
			end
			qpht_pkg::MOD_STEP: begin
				dividend = qpht_pkg::key_t'(step_sum) << qpht_pkg::COEFF_SHIFT;
				digits   = qpht_pkg::dcnt_t'(qpht_pkg::COEFF_DIGITS);
			end
			default: begin
				dividend = s_abs;
				digits   = qpht_pkg::dcnt_t'(qpht_pkg::KEY_DIGITS);
			end
		endcase
	end

	qpht_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.mod_start),
		.dividend (dividend),
		.digits   (digits),
		.divisor  (m_eff),
		.done     (rem_done),
		.rem      (rem_val)
	);

	// A negative key with a non-zero remainder of its magnitude folds back
	// into the range 0 .. m-1.
	assign home = (key_q[qpht_pkg::KEY_W-1] && (rem_val != '0)) ? m_eff - rem_val : rem_val;

	// Successive probe positions differ by c1 + c2*(2i+1), so position and
	// difference each advance by one modular addition.
	always_comb begin
		pos_sum    = {1'b0, pos_q} + {1'b0, delta_q};
		delta_sum  = {1'b0, delta_q} + {1'b0, step_q};
		pos_next   = (pos_sum >= {1'b0, m_eff}) ?
			qpht_pkg::mod_t'(pos_sum - {1'b0, m_eff}) : pos_sum[qpht_pkg::MOD_W-1:0];
		delta_next = (delta_sum >= {1'b0, m_eff}) ?
			qpht_pkg::mod_t'(delta_sum - {1'b0, m_eff}) : delta_sum[qpht_pkg::MOD_W-1:0];
	end

	assign ram_addr   = qpht_pkg::slot_idx_t'(pos_q);
	assign occ_hit    = occ_q[ram_addr];
	assign key_match  = (ram_rdata == key_q);
	assign last_probe = (idx_q == m_eff - qpht_pkg::mod_t'(1));
	assign ram_we     = cmd.commit && (req_q == qpht_pkg::REQ_INSERT) && !occ_hit;

	qpht_ram #(
		.WIDTH (qpht_pkg::KEY_W),
		.DEPTH (qpht_pkg::TABLE_DEPTH)
	) u_keys (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_addr),
		.wdata (key_q),
		.raddr (ram_addr),
		.rdata (ram_rdata)
	);

	always_comb begin
		res_slot = '0;
		if (req_q == qpht_pkg::REQ_INSERT) begin
			if (!occ_hit) begin
				res_outcome = qpht_pkg::OUT_INSERTED;
				res_slot    = qpht_pkg::SLOT_OUT_W'(pos_q);
			end else begin
				res_outcome = qpht_pkg::OUT_FULL;
			end
		end else if (occ_hit && key_match) begin
			res_outcome = qpht_pkg::OUT_FOUND;
			res_slot    = qpht_pkg::SLOT_OUT_W'(pos_q);
		end else begin
			res_outcome = qpht_pkg::OUT_NOT_FOUND;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			key_q <= s_tdata;
			req_q <= qpht_pkg::req_t'(s_tuser);
			idx_q <= '0;
		end
		if (cmd.mod_start) begin
			sel_q <= cmd.mod_sel;
		end
		if (rem_done) begin
			unique case (sel_q)
				qpht_pkg::MOD_KEY:  pos_q   <= home;
				qpht_pkg::MOD_LIN:  delta_q <= rem_val;
				qpht_pkg::MOD_STEP: step_q  <= rem_val;
				default: ;
			endcase
		end
		if (cmd.probe_adv) begin
			pos_q   <= pos_next;
			delta_q <= delta_next;
			idx_q   <= idx_q + qpht_pkg::mod_t'(1);
		end
		if (cmd.commit) begin
			outcome_q <= res_outcome;
			slot_q    <= res_slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ram_we) begin
				occ_q[ram_addr] <= 1'b1;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.mod_done = rem_done;
	assign stat.finish   = !occ_hit || ((req_q == qpht_pkg::REQ_SEARCH) && key_match) || last_probe;
	assign stat.out_free = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = qpht_pkg::out_data_t'(slot_q);
	assign m_tuser  = outcome_q;

endmodule

>>> design/qpht_ctrl.sv
// Controller of the hash table: sequences the residue computations and the probe loop.
// Depends on qpht_pkg for the command and status structures.
module qpht_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  qpht_pkg::dp_stat_t stat,
	output qpht_pkg::ctl_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_KEY,
		S_LIN,
		S_STEP,
		S_READ,
		S_CHECK
	} state_t;

	state_t state_q;
	state_t state_nx;

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.mod_sel = qpht_pkg::MOD_KEY;
				if (s_tvalid) begin
					cmd.accept    = 1'b1;
					cmd.mod_start = 1'b1;
					state_nx      = S_KEY;
				end
			end
			S_KEY: begin
				if (stat.mod_done) begin
					cmd.mod_start = 1'b1;
					cmd.mod_sel   = qpht_pkg::MOD_LIN;
					state_nx      = S_LIN;
				end
			end
			S_LIN: begin
				if (stat.mod_done) begin
					cmd.mod_start = 1'b1;
					cmd.mod_sel   = qpht_pkg::MOD_STEP;
					state_nx      = S_STEP;
				end
			end
			S_STEP: begin
				if (stat.mod_done) begin
					state_nx = S_READ;
				end
			end
			// The key memory has a registered read port, so the lookup waits here for its data.
			S_READ: state_nx = S_CHECK;
			S_CHECK: begin
				if (stat.finish) begin
					if (stat.out_free) begin
						cmd.commit = 1'b1;
						state_nx   = S_IDLE;
					end
				end else begin
					cmd.probe_adv = 1'b1;
					state_nx      = S_READ;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	assign s_tready = (state_q == S_IDLE);

endmodule

>>> design/quadratic_probe_hash_table.sv
// Top level of the quadratic probe hash table: controller plus datapath.
// Depends on qpht_pkg, qpht_ctrl and qpht_dp.
//
//   Channel   Direction  Contents
//   s_*       in         request: tuser = req_type, tdata = key
//   m_*       out        result:  tuser = outcome,  tdata = slot
//   cfg_*     in         register write: table_size, linear_coeff, square_coeff
//
// A transaction first computes the key and coefficient residues, then probes; each
// probe sets the address, then checks the registered key memory read.
// The residues come from a remainder unit working one 4-bit digit per cycle.
// Reset clears the occupancy flags at once and loads the register defaults.
// A result waits in the output register while the next request is taken; a
// finished lookup holds in its check state until that register is free.
module quadratic_probe_hash_table (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [qpht_pkg::KEY_W-1:0]           s_tdata,   // [31:0] key
	input  logic                                 s_tuser,   // [0] req_type
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [qpht_pkg::OUT_DATA_W-1:0]      m_tdata,   // [6:0] slot, [7] zero
	output logic [1:0]                           m_tuser,   // [1:0] outcome
	input  logic                                 cfg_we,
	input  logic [qpht_pkg::CFG_ADDR_W-1:0]      cfg_addr,
	input  logic [qpht_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

	qpht_pkg::ctl_cmd_t cmd;
	qpht_pkg::dp_stat_t stat;

	qpht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	qpht_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

endmodule

>>> design/qpht_checker.sv
// Port-level checks of the hash table and the bind that attaches them.
// Depends on qpht_pkg and the shared assertion macro header.
`include "quadratic_probe_hash_table_macros.svh"

module qpht_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [qpht_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic [1:0]                      m_tuser
);

	logic no_slot_outcome;

	assign no_slot_outcome = (m_tuser == qpht_pkg::OUT_FULL) ||
		(m_tuser == qpht_pkg::OUT_NOT_FOUND);

	// A stalled result stays offered and unchanged.
	`QPHT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
	`QPHT_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser))

	// Requests are worked on one at a time: an accepted request leaves the input not ready.
	`QPHT_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

	// A miss or a full table never reports a slot.
	`QPHT_ASSERT_NOW(a_no_slot_on_miss, m_tvalid && no_slot_outcome, m_tdata == '0)

endmodule

bind quadratic_probe_hash_table qpht_checker u_checker (.*);

>>> tb/quadratic_probe_hash_table_test.sv
// Self-checking testbench for the quadratic probe hash table: drives insert and search
// requests over the stream ports and compares each result with a table predictor.
// Depends on qpht_pkg and the quadratic_probe_hash_table RTL only.
`timescale 1ns / 1ps

class probe_table_scoreboard;

	typedef struct {
		qpht_pkg::outcome_t              outcome;
		logic [qpht_pkg::SLOT_OUT_W-1:0] slot;
	} lookup_result_t;

	logic [qpht_pkg::SIZE_W-1:0]  size_reg;
	logic [qpht_pkg::COEFF_W-1:0] linear_reg;
	logic [qpht_pkg::COEFF_W-1:0] square_reg;
	qpht_pkg::key_t               slot_key[qpht_pkg::TABLE_DEPTH];
	bit                           slot_used[qpht_pkg::TABLE_DEPTH];
	lookup_result_t               awaited_results[$];
	int                           mismatches;
	int                           results_checked;

	function new();
		size_reg = qpht_pkg::SIZE_W'(qpht_pkg::TABLE_DEPTH);
		linear_reg = qpht_pkg::COEFF_W'(1);
		square_reg = qpht_pkg::COEFF_W'(1);
		foreach (slot_used[n]) slot_used[n] = 1'b0;
		mismatches = 0;
		results_checked = 0;
	endfunction

	function void write_reg(logic [qpht_pkg::CFG_ADDR_W-1:0] index,
			logic [qpht_pkg::CFG_DATA_W-1:0] value);
		if (index == qpht_pkg::CFG_TABLE_SIZE) size_reg = value[qpht_pkg::SIZE_W-1:0];
		else if (index == qpht_pkg::CFG_LINEAR_COEFF) linear_reg = value[qpht_pkg::COEFF_W-1:0];
		else if (index == qpht_pkg::CFG_SQUARE_COEFF) square_reg = value[qpht_pkg::COEFF_W-1:0];
	endfunction

	function longint eff_size();
		longint m;
		m = longint'(size_reg);
		if (m == 0) m = 1;
		if (m > qpht_pkg::TABLE_DEPTH) m = qpht_pkg::TABLE_DEPTH;
		return m;
	endfunction

	// Walks the probe sequence for one request and queues the result it must give.
	function void note_request(qpht_pkg::req_t kind, qpht_pkg::key_t key);
		longint m;
		longint home;
		longint i;
		longint j;
		lookup_result_t res;
		m = eff_size();
		home = longint'($signed(key)) % m;
		if (home < 0) home += m;
		if (kind == qpht_pkg::REQ_SEARCH) res.outcome = qpht_pkg::OUT_NOT_FOUND;
		else res.outcome = qpht_pkg::OUT_FULL;
		res.slot = '0;
		for (i = 0; i < m; i++) begin
			j = (home + longint'(linear_reg) * i + longint'(square_reg) * i * i) % m;
			if (kind == qpht_pkg::REQ_INSERT) begin
				if (!slot_used[j]) begin
					slot_key[j] = key;
					slot_used[j] = 1'b1;
					res.outcome = qpht_pkg::OUT_INSERTED;
					res.slot = j[qpht_pkg::SLOT_OUT_W-1:0];
					break;
				end
			end else begin
				if (!slot_used[j]) break;
				if (slot_key[j] == key) begin
					res.outcome = qpht_pkg::OUT_FOUND;
					res.slot = j[qpht_pkg::SLOT_OUT_W-1:0];
					break;
				end
			end
		end
		awaited_results.push_back(res);
	endfunction

	task report_mismatch(string what);
		mismatches++;
		$display("mismatch %0d at %0t: %s", mismatches, $realtime, what);
	endtask

	task check_result(logic [1:0] outcome, logic [qpht_pkg::OUT_DATA_W-1:0] data);
		lookup_result_t exp;
		results_checked++;
		if (awaited_results.size() == 0) begin
			report_mismatch($sformatf("unexpected result, outcome %0d data %0d", outcome, data));
			return;
		end
		exp = awaited_results.pop_front();
		if (outcome !== exp.outcome)
			report_mismatch($sformatf("result %0d outcome %0d, expected %0d",
				results_checked, outcome, exp.outcome));
		if (data !== qpht_pkg::OUT_DATA_W'(exp.slot))
			report_mismatch($sformatf("result %0d slot %0d, expected %0d",
				results_checked, data, exp.slot));
	endtask

endclass

module quadratic_probe_hash_table_test;

	localparam logic [qpht_pkg::CFG_ADDR_W-1:0] CFG_UNUSED_INDEX = 2'd3;
	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int STAGE_LEN   = 490;
	localparam int TAIL_CYCLES = 300;
	localparam int HOLD_AT     = 200;
	localparam int HOLD_CYCLES = 600;

	logic                              clk;
	logic                              arst_n;
	logic                              s_tvalid;
	logic                              s_tready;
	logic [qpht_pkg::KEY_W-1:0]        s_tdata;   // [31:0] key
	logic                              s_tuser;   // [0] req_type
	logic                              m_tvalid;
	logic                              m_tready;
	logic [qpht_pkg::OUT_DATA_W-1:0]   m_tdata;   // [6:0] slot, [7] zero
	logic [1:0]                        m_tuser;   // [1:0] outcome
	logic                              cfg_we;
	logic [qpht_pkg::CFG_ADDR_W-1:0]   cfg_addr;
	logic [qpht_pkg::CFG_DATA_W-1:0]   cfg_wdata;

	probe_table_scoreboard table_model;
	qpht_pkg::key_t        key_pool[$];
	int                    requests_sent;
	int                    cycle_count;
	int unsigned           tx_idle_pct;
	int unsigned           rx_idle_pct;

	quadratic_probe_hash_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("quadratic_probe_hash_table test failed");
			$finish;
		end
	end

	task automatic write_reg(input logic [qpht_pkg::CFG_ADDR_W-1:0] index,
			input logic [qpht_pkg::CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_addr <= index;
		cfg_wdata <= value;
		@(posedge clk);
		table_model.write_reg(index, value);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Each cycle before the request is offered, the sender may idle instead.
	task automatic send_request(input qpht_pkg::req_t kind, input qpht_pkg::key_t key);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= key;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		table_model.note_request(kind, key);
		if (kind == qpht_pkg::REQ_INSERT) begin
			key_pool.push_back(key);
			if (key_pool.size() > 256) void'(key_pool.pop_front());
		end
		requests_sent++;
		if (requests_sent == STAGE_LEN) begin
			tx_idle_pct = 73;
			rx_idle_pct = 37;
		end else if (requests_sent == 2 * STAGE_LEN) begin
			tx_idle_pct = 0;
			rx_idle_pct = 0;
		end
	endtask

	// Stop offering requests and wait for every outstanding result.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (table_model.awaited_results.size() != 0) @(posedge clk);
	endtask

	// Mostly keys already inserted, some shifted by multiples of m so that they
	// share a home slot, plus corner values and fully random keys.
	function automatic qpht_pkg::key_t choose_key(bit from_pool);
		qpht_pkg::key_t k;
		longint m;
		m = table_model.eff_size();
		if (from_pool && key_pool.size() != 0) begin
			k = key_pool[$urandom_range(key_pool.size() - 1)];
			if ($urandom_range(3) == 0)
				k = k + qpht_pkg::key_t'(longint'($urandom_range(1, 3)) * m);
		end else begin
			case ($urandom_range(7))
				0: k = 32'h8000_0000;
				1: k = 32'h7fff_ffff;
				2: k = '1;
				3: k = qpht_pkg::key_t'(-m);
				default: k = $urandom();
			endcase
		end
		return k;
	endfunction

	task automatic run_phase(input logic [qpht_pkg::CFG_DATA_W-1:0] size_val,
			input logic [qpht_pkg::CFG_DATA_W-1:0] lin_val,
			input logic [qpht_pkg::CFG_DATA_W-1:0] sq_val,
			input int count);
		qpht_pkg::req_t kind;
		qpht_pkg::key_t key;
		settle();
		write_reg(qpht_pkg::CFG_TABLE_SIZE, size_val);
		write_reg(qpht_pkg::CFG_LINEAR_COEFF, lin_val);
		write_reg(qpht_pkg::CFG_SQUARE_COEFF, sq_val);
		if ($urandom_range(1) == 1)
			write_reg(CFG_UNUSED_INDEX, qpht_pkg::CFG_DATA_W'($urandom()));
		repeat (count) begin
			if ($urandom_range(99) < 65) begin
				kind = qpht_pkg::REQ_SEARCH;
				key = choose_key($urandom_range(99) < 75);
			end else begin
				kind = qpht_pkg::REQ_INSERT;
				key = choose_key($urandom_range(99) < 40);
			end
			send_request(kind, key);
		end
	endtask

	// Result side: checks every transaction and stalls at random, with one long
	// hold-off so that the block backs up into its input.
	initial begin
		int hold_left;
		bit held_once;
		hold_left = 0;
		held_once = 1'b0;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) table_model.check_result(m_tuser, m_tdata);
			if (!held_once && table_model.results_checked == HOLD_AT) begin
				held_once = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	initial begin
		table_model = new();
		cycle_count = 0;
		requests_sent = 0;
		tx_idle_pct = 37;
		rx_idle_pct = 73;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Default registers: extreme keys, home collisions, duplicates.
		send_request(qpht_pkg::REQ_INSERT, 32'h0000_0000);
		send_request(qpht_pkg::REQ_INSERT, 32'hffff_ffff);
		send_request(qpht_pkg::REQ_INSERT, 32'h7fff_ffff);
		send_request(qpht_pkg::REQ_INSERT, 32'h8000_0000);
		send_request(qpht_pkg::REQ_INSERT, 32'h0000_0000);
		send_request(qpht_pkg::REQ_SEARCH, 32'h0000_0000);
		send_request(qpht_pkg::REQ_SEARCH, 32'h8000_0000);
		send_request(qpht_pkg::REQ_SEARCH, 32'hffff_ffff);
		send_request(qpht_pkg::REQ_SEARCH, 32'd5);
		send_request(qpht_pkg::REQ_SEARCH, 32'd128);
		send_request(qpht_pkg::REQ_INSERT, 32'd128);
		send_request(qpht_pkg::REQ_SEARCH, 32'd128);

		// A size of zero behaves as a single slot, which is already taken.
		settle();
		write_reg(qpht_pkg::CFG_TABLE_SIZE, '0);
		send_request(qpht_pkg::REQ_SEARCH, 32'h0000_0000);
		send_request(qpht_pkg::REQ_INSERT, 32'd7);
		send_request(qpht_pkg::REQ_SEARCH, 32'd7);

		// Oversized size is clamped; zero coefficients revisit the home slot only,
		// so free slots elsewhere are never reached.
		settle();
		write_reg(qpht_pkg::CFG_TABLE_SIZE, '1);
		write_reg(qpht_pkg::CFG_LINEAR_COEFF, '0);
		write_reg(qpht_pkg::CFG_SQUARE_COEFF, '0);
		send_request(qpht_pkg::REQ_INSERT, 32'd256);
		send_request(qpht_pkg::REQ_SEARCH, 32'd128);

		// The write to the unused index must change nothing; the shrunk table
		// leaves slot 127 in place but out of reach.
		settle();
		write_reg(CFG_UNUSED_INDEX, '1);
		write_reg(qpht_pkg::CFG_TABLE_SIZE, 10'd2);
		send_request(qpht_pkg::REQ_SEARCH, 32'hffff_ffff);
		send_request(qpht_pkg::REQ_SEARCH, 32'h7fff_ffff);

		run_phase(10'd8,   10'd1,    10'd1,    120);
		run_phase(10'd1,   10'd0,    10'd1023, 60);
		run_phase(10'd3,   10'd7,    10'd2,    100);
		run_phase(10'd16,  10'd0,    10'd1,    150);
		run_phase(10'd37,  10'd1023, 10'd1023, 150);
		run_phase(10'd50,  10'd5,    10'd9,    90);
		run_phase(10'd64,  10'd3,    10'd0,    150);
		run_phase(10'h2c8, 10'd512,  10'd1,    150);
		run_phase(10'd127, 10'd0,    10'd0,    120);
		run_phase(10'd128, 10'd1,    10'd1,    150);
		run_phase(10'd100, 10'd2,    10'd2,    150);
		run_phase(10'd0,   10'd1023, 10'd0,    60);

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (table_model.awaited_results.size() != 0)
			table_model.report_mismatch("results still outstanding at the end");
		if (table_model.mismatches == 0) begin
			$display("quadratic_probe_hash_table test passed");
		end else begin
			$display("quadratic_probe_hash_table test failed");
		end
		$finish;
	end

endmodule

>>> quadratic_probe_hash_table.f
+incdir+design
design/qpht_pkg.sv
design/qpht_ram.sv
design/qpht_rem.sv
design/qpht_dp.sv
design/qpht_ctrl.sv
design/quadratic_probe_hash_table.sv
design/qpht_checker.sv
tb/quadratic_probe_hash_table_test.sv
